// ===== sv/pms_pkg.sv =====
package pms_pkg;

    // Operating mode codes, as reported on the mode output
    typedef enum logic [3:0] {
        MODE_PREFLIGHT = 4'd0,
        MODE_LAUNCH    = 4'd1,
        MODE_KILL      = 4'd2,
        MODE_RESTART   = 4'd3,
        MODE_EMERGENCY = 4'd4,
        MODE_DET_POST  = 4'd5,
        MODE_DET_PRE   = 4'd6,
        MODE_UPLINK    = 4'd7,
        MODE_TRANSMIT  = 4'd8,
        MODE_IDLE      = 4'd9,
        MODE_LOW       = 4'd10,
        MODE_EXTREME   = 4'd11
    } t_mode;

    // Rail group switch actions
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ON    = 2'd1,
        ACT_OFF   = 2'd2,
        ACT_CYCLE = 2'd3
    } t_act;

    // Configuration register indexes
    localparam logic [2:0] CFG_KILL_CODE       = 3'd0;
    localparam logic [2:0] CFG_RESTART_CODE    = 3'd1;
    localparam logic [2:0] CFG_LAUNCH_STATUS   = 3'd2;
    localparam logic [2:0] CFG_RATE_LIMIT      = 3'd3;
    localparam logic [2:0] CFG_NORMAL_THRESH   = 3'd4;
    localparam logic [2:0] CFG_LOW_FLOOR       = 3'd5;
    localparam logic [2:0] CFG_LOW_EXIT        = 3'd6;
    localparam logic [2:0] CFG_EXTREME_EXIT    = 3'd7;

    // Status byte codes
    localparam logic [7:0]  EMERGENCY_REQ   = 8'h11;
    localparam logic [7:0]  DEPLOYED        = 8'hA0;
    localparam logic [7:0]  IMAGE_UPLINK    = 8'hFF;
    localparam logic [7:0]  LAUNCH_MASK     = 8'hC0;
    localparam logic [11:0] THRESHOLD_RESET = 12'h00A;
    localparam logic [7:0]  REPORT_SAME     = 8'h58; // 'X'

    // Register reset values
    localparam logic [7:0]  RST_KILL_CODE     = 8'd0;
    localparam logic [7:0]  RST_RESTART_CODE  = 8'd1;
    localparam logic [7:0]  RST_LAUNCH_STATUS = 8'd0;
    localparam logic [7:0]  RST_RATE_LIMIT    = 8'd128;
    localparam logic [11:0] RST_NORMAL_THRESH = 12'd3300;
    localparam logic [11:0] RST_LOW_FLOOR     = 12'd3000;
    localparam logic [11:0] RST_LOW_EXIT      = 12'd3500;
    localparam logic [11:0] RST_EXTREME_EXIT  = 12'd4000;

    typedef struct packed {
        logic [7:0]  kill_code;
        logic [7:0]  restart_code;
        logic [7:0]  launch_status;
        logic [7:0]  rate_limit;
        logic [11:0] normal_threshold;
        logic [11:0] low_floor;
        logic [11:0] low_exit_threshold;
        logic [11:0] extreme_exit_threshold;
    } t_cfg;

    typedef struct packed {
        logic        remove_before_flight;
        logic [7:0]  cmd_byte;
        logic [7:0]  emergency_code;
        logic [11:0] battery_voltage;
        logic [7:0]  angular_rate;
        logic [7:0]  deploy_status;
        logic [7:0]  image_status;
        logic [7:0]  sat_position;
        logic [7:0]  region_bound;
    } t_sample;

    typedef struct packed {
        t_mode      mode;
        logic       mode_changed;
        logic [7:0] report_byte;
        t_act       main_rails_action;
        t_act       aux_rails_action;
        logic       halted;
    } t_result;

    // ASCII report letter for a newly entered mode
    function automatic logic [7:0] report_char(input t_mode m);
        logic [7:0] c;
        case (m)
            MODE_PREFLIGHT: c = 8'h41; // A
            MODE_LAUNCH:    c = 8'h42; // B
            MODE_KILL:      c = 8'h4B; // K
            MODE_RESTART:   c = 8'h4A; // J
            MODE_EMERGENCY: c = 8'h50; // P
            MODE_DET_POST:  c = 8'h44; // D
            MODE_DET_PRE:   c = 8'h43; // C
            MODE_UPLINK:    c = 8'h47; // G
            MODE_TRANSMIT:  c = 8'h46; // F
            MODE_IDLE:      c = 8'h45; // E
            MODE_LOW:       c = 8'h48; // H
            MODE_EXTREME:   c = 8'h49; // I
            default:        c = REPORT_SAME;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/pms_cfg_regs.sv =====
module pms_cfg_regs
    import pms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register file, one write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kill_code              <= RST_KILL_CODE;
            r_cfg.restart_code           <= RST_RESTART_CODE;
            r_cfg.launch_status          <= RST_LAUNCH_STATUS;
            r_cfg.rate_limit             <= RST_RATE_LIMIT;
            r_cfg.normal_threshold       <= RST_NORMAL_THRESH;
            r_cfg.low_floor              <= RST_LOW_FLOOR;
            r_cfg.low_exit_threshold     <= RST_LOW_EXIT;
            r_cfg.extreme_exit_threshold <= RST_EXTREME_EXIT;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_KILL_CODE:     r_cfg.kill_code              <= i_cfg_wdata[7:0];
                CFG_RESTART_CODE:  r_cfg.restart_code           <= i_cfg_wdata[7:0];
                CFG_LAUNCH_STATUS: r_cfg.launch_status          <= i_cfg_wdata[7:0];
                CFG_RATE_LIMIT:    r_cfg.rate_limit             <= i_cfg_wdata[7:0];
                CFG_NORMAL_THRESH: r_cfg.normal_threshold       <= i_cfg_wdata;
                CFG_LOW_FLOOR:     r_cfg.low_floor              <= i_cfg_wdata;
                CFG_LOW_EXIT:      r_cfg.low_exit_threshold     <= i_cfg_wdata;
                CFG_EXTREME_EXIT:  r_cfg.extreme_exit_threshold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/pms_decide.sv =====
module pms_decide
    import pms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_mode       r_mode;
    logic [11:0] r_thresh;
    logic        r_killed;

    t_mode       n_mode;
    logic [11:0] n_thresh;
    logic        n_killed;
    t_result     res;

    // Priority mode choice and rail actions for one item
    always_comb begin
        n_thresh = r_thresh;
        n_killed = r_killed;
        res      = '{mode: r_mode, mode_changed: 1'b0, report_byte: REPORT_SAME,
                     main_rails_action: ACT_NONE, aux_rails_action: ACT_NONE,
                     halted: r_killed};

        if (i_sample.remove_before_flight) begin
            n_mode = MODE_PREFLIGHT;
        end else if ((i_cfg.launch_status & LAUNCH_MASK) != 8'h00) begin
            n_mode = MODE_LAUNCH;
        end else if (i_sample.cmd_byte == i_cfg.kill_code) begin
            n_mode = MODE_KILL;
        end else if (i_sample.cmd_byte == i_cfg.restart_code) begin
            n_mode = MODE_RESTART;
        end else if (i_sample.emergency_code == EMERGENCY_REQ) begin
            n_mode = MODE_EMERGENCY;
        end else if (i_sample.battery_voltage > r_thresh) begin
            n_thresh = i_cfg.normal_threshold;
            if (i_sample.angular_rate > i_cfg.rate_limit) begin
                n_mode = (i_sample.deploy_status == DEPLOYED) ? MODE_DET_POST : MODE_DET_PRE;
            end else if (i_sample.sat_position > i_sample.region_bound) begin
                n_mode = (i_sample.image_status == IMAGE_UPLINK) ? MODE_UPLINK : MODE_TRANSMIT;
            end else begin
                n_mode = MODE_IDLE;
            end
        end else if (r_mode == MODE_EXTREME) begin
            n_mode   = MODE_EXTREME;
            n_thresh = i_cfg.extreme_exit_threshold;
        end else if (i_sample.battery_voltage > i_cfg.low_floor) begin
            n_mode   = MODE_LOW;
            n_thresh = i_cfg.low_exit_threshold;
        end else begin
            n_mode   = MODE_EXTREME;
            n_thresh = i_cfg.extreme_exit_threshold;
        end

        res.mode = n_mode;
        if (n_mode != r_mode) begin
            res.mode_changed = 1'b1;
            res.report_byte  = report_char(n_mode);
            case (n_mode)
                MODE_IDLE, MODE_TRANSMIT, MODE_UPLINK: begin
                    if (r_mode == MODE_EXTREME) begin
                        res.main_rails_action = ACT_ON;
                        res.aux_rails_action  = ACT_ON;
                    end else if (r_mode == MODE_LOW) begin
                        res.main_rails_action = ACT_ON;
                    end
                end
                MODE_LOW: begin
                    res.main_rails_action = ACT_OFF;
                end
                MODE_EXTREME, MODE_KILL: begin
                    res.main_rails_action = ACT_OFF;
                    res.aux_rails_action  = ACT_OFF;
                end
                MODE_RESTART: begin
                    res.main_rails_action = ACT_CYCLE;
                    res.aux_rails_action  = ACT_CYCLE;
                end
                default: ;
            endcase
            if (n_mode == MODE_KILL) begin
                n_killed   = 1'b1;
                res.halted = 1'b1;
            end
        end

        // Once halted, inputs are ignored and the state is frozen
        if (r_killed) begin
            n_mode   = r_mode;
            n_thresh = r_thresh;
            res      = '{mode: MODE_KILL, mode_changed: 1'b0, report_byte: REPORT_SAME,
                         main_rails_action: ACT_NONE, aux_rails_action: ACT_NONE,
                         halted: 1'b1};
        end
    end

    // Mode, hysteresis threshold and kill latch advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PREFLIGHT;
            r_thresh <= THRESHOLD_RESET;
            r_killed <= 1'b0;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_thresh <= n_thresh;
            r_killed <= n_killed;
        end
    end

    assign o_result = res;

endmodule

// ===== sv/power_mode_sequencer_core.sv =====
// Power mode sequencer.
// Input channel (i_valid / o_ready) carries one status sample per item; the
// output channel (o_valid / i_ready) returns exactly one result item per
// sample: new mode, change flag, ASCII report byte, two rail group actions
// and the halted flag. Configuration registers are written through
// i_cfg_wen / i_cfg_addr / i_cfg_wdata and take effect on the next item.
// An item is first held in the input register, then the mode decision logic
// loads the result register and o_valid rises.
// Throughput is one item per cycle while the receiver does not stall; the mode
// and threshold registers are updated in the same cycle the item moves into
// the result register.
// If the receiver stalls, the result register holds and the input register
// keeps one more item; o_ready drops only when both are full.
// Reset (synchronous, active low) empties both stages, restores register
// defaults, sets preflight mode, a threshold of 10 and clears the kill latch.
// After kill mode is entered every item reports kill, unchanged, until reset.
module power_mode_sequencer_core
    import pms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    // sample input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_remove_before_flight,
    input  logic [7:0]  i_cmd_byte,
    input  logic [7:0]  i_emergency_code,
    input  logic [11:0] i_battery_voltage,
    input  logic [7:0]  i_angular_rate,
    input  logic [7:0]  i_deploy_status,
    input  logic [7:0]  i_image_status,
    input  logic [7:0]  i_sat_position,
    input  logic [7:0]  i_region_bound,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_mode,
    output logic        o_mode_changed,
    output logic [7:0]  o_report_byte,
    output logic [1:0]  o_main_rails_action,
    output logic [1:0]  o_aux_rails_action,
    output logic        o_halted
);

    t_cfg    cfg;
    t_result result;
    t_sample r_sample;
    t_result r_result;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    advance;

    pms_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pms_decide u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_sample  (r_sample),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Item moves from input register to result register
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= '{remove_before_flight: i_remove_before_flight,
                          cmd_byte: i_cmd_byte,
                          emergency_code: i_emergency_code,
                          battery_voltage: i_battery_voltage,
                          angular_rate: i_angular_rate,
                          deploy_status: i_deploy_status,
                          image_status: i_image_status,
                          sat_position: i_sat_position,
                          region_bound: i_region_bound};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_mode              = r_result.mode;
    assign o_mode_changed      = r_result.mode_changed;
    assign o_report_byte       = r_result.report_byte;
    assign o_main_rails_action = r_result.main_rails_action;
    assign o_aux_rails_action  = r_result.aux_rails_action;
    assign o_halted            = r_result.halted;

endmodule

// ===== tb/power_mode_sequencer_core_tb.sv =====
`timescale 1ns / 100ps

module power_mode_sequencer_core_tb;
    import pms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_CYCLES = 10;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // Block inputs, all known from time zero
    logic        i_cfg_wen = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [11:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    t_sample     in_item = '0;

    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_mode;
    logic        o_mode_changed;
    logic [7:0]  o_report_byte;
    logic [1:0]  o_main_rails_action;
    logic [1:0]  o_aux_rails_action;
    logic        o_halted;

    power_mode_sequencer_core dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wen              (i_cfg_wen),
        .i_cfg_addr             (i_cfg_addr),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_remove_before_flight (in_item.remove_before_flight),
        .i_cmd_byte             (in_item.cmd_byte),
        .i_emergency_code       (in_item.emergency_code),
        .i_battery_voltage      (in_item.battery_voltage),
        .i_angular_rate         (in_item.angular_rate),
        .i_deploy_status        (in_item.deploy_status),
        .i_image_status         (in_item.image_status),
        .i_sat_position         (in_item.sat_position),
        .i_region_bound         (in_item.region_bound),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_mode                 (o_mode),
        .o_mode_changed         (o_mode_changed),
        .o_report_byte          (o_report_byte),
        .o_main_rails_action    (o_main_rails_action),
        .o_aux_rails_action     (o_aux_rails_action),
        .o_halted               (o_halted)
    );

    // Shadow copy of the sequencer: settings and state
    t_cfg        cfg;
    t_mode       cur_mode;
    logic [11:0] volt_thresh;
    logic        killed;

    t_sample pending_items[$];
    t_result expected_results[$];

    int  mismatches = 0;
    int  samples_sent = 0;
    int  results_checked = 0;
    int  mode_changes = 0;
    int  rail_events = 0;
    int  settings_loaded = 0;
    int  cycles = 0;
    int  idle_odds = 4;
    int  drift_volt = 2048;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;

    // Letter reported on entry to a mode
    function automatic logic [7:0] mode_letter(input t_mode m);
        logic [7:0] c;
        case (m)
            MODE_PREFLIGHT: c = "A";
            MODE_LAUNCH:    c = "B";
            MODE_KILL:      c = "K";
            MODE_RESTART:   c = "J";
            MODE_EMERGENCY: c = "P";
            MODE_DET_POST:  c = "D";
            MODE_DET_PRE:   c = "C";
            MODE_UPLINK:    c = "G";
            MODE_TRANSMIT:  c = "F";
            MODE_IDLE:      c = "E";
            MODE_LOW:       c = "H";
            default:        c = "I";
        endcase
        return c;
    endfunction

    // Next mode, report and rail actions for one sample; advances the shadow state
    function automatic t_result sequence_mode(input t_sample s);
        t_result r;
        t_mode   nxt;
        r.mode = MODE_KILL;
        r.mode_changed = 1'b0;
        r.report_byte = "X";
        r.main_rails_action = ACT_NONE;
        r.aux_rails_action = ACT_NONE;
        r.halted = 1'b1;
        if (killed)
            return r;

        // priority chain; threshold only moves in the battery branch
        if (s.remove_before_flight)
            nxt = MODE_PREFLIGHT;
        else if ((cfg.launch_status & LAUNCH_MASK) != 8'd0)
            nxt = MODE_LAUNCH;
        else if (s.cmd_byte == cfg.kill_code)
            nxt = MODE_KILL;
        else if (s.cmd_byte == cfg.restart_code)
            nxt = MODE_RESTART;
        else if (s.emergency_code == EMERGENCY_REQ)
            nxt = MODE_EMERGENCY;
        else if (s.battery_voltage > volt_thresh) begin
            volt_thresh = cfg.normal_threshold;
            if (s.angular_rate > cfg.rate_limit)
                nxt = (s.deploy_status == DEPLOYED) ? MODE_DET_POST : MODE_DET_PRE;
            else if (s.sat_position > s.region_bound)
                nxt = (s.image_status == IMAGE_UPLINK) ? MODE_UPLINK : MODE_TRANSMIT;
            else
                nxt = MODE_IDLE;
        end else if (cur_mode == MODE_EXTREME) begin
            nxt = MODE_EXTREME;
            volt_thresh = cfg.extreme_exit_threshold;
        end else if (s.battery_voltage > cfg.low_floor) begin
            nxt = MODE_LOW;
            volt_thresh = cfg.low_exit_threshold;
        end else begin
            nxt = MODE_EXTREME;
            volt_thresh = cfg.extreme_exit_threshold;
        end

        r.mode = nxt;
        if (nxt != cur_mode) begin
            r.mode_changed = 1'b1;
            r.report_byte = mode_letter(nxt);
            case (nxt)
                MODE_IDLE, MODE_TRANSMIT, MODE_UPLINK: begin
                    if (cur_mode == MODE_EXTREME) begin
                        r.main_rails_action = ACT_ON;
                        r.aux_rails_action = ACT_ON;
                    end else if (cur_mode == MODE_LOW) begin
                        r.main_rails_action = ACT_ON;
                    end
                end
                MODE_LOW: r.main_rails_action = ACT_OFF;
                MODE_EXTREME, MODE_KILL: begin
                    r.main_rails_action = ACT_OFF;
                    r.aux_rails_action = ACT_OFF;
                end
                MODE_RESTART: begin
                    r.main_rails_action = ACT_CYCLE;
                    r.aux_rails_action = ACT_CYCLE;
                end
                default: ;
            endcase
            if (nxt == MODE_KILL)
                killed = 1'b1;
            mode_changes++;
            if (r.main_rails_action != ACT_NONE || r.aux_rails_action != ACT_NONE)
                rail_events++;
        end
        r.halted = killed;
        cur_mode = nxt;
        return r;
    endfunction

    function automatic t_sample sample_of(input logic rbf, input logic [7:0] cmd,
                                          input logic [7:0] emerg, input logic [11:0] volt,
                                          input logic [7:0] rate, input logic [7:0] deploy,
                                          input logic [7:0] image, input logic [7:0] pos,
                                          input logic [7:0] bound);
        t_sample s;
        s.remove_before_flight = rbf;
        s.cmd_byte = cmd;
        s.emergency_code = emerg;
        s.battery_voltage = volt;
        s.angular_rate = rate;
        s.deploy_status = deploy;
        s.image_status = image;
        s.sat_position = pos;
        s.region_bound = bound;
        return s;
    endfunction

    // Random sample: voltage drifts slowly, lands on a threshold or is drawn at random;
    // with no_kill set, a command that would reach the kill branch is bumped
    function automatic t_sample random_sample(input bit no_kill);
        t_sample s;
        int v;
        int t;
        s.remove_before_flight = ($urandom_range(15, 0) == 0);
        case ($urandom_range(19, 0))
            0:       s.cmd_byte = cfg.kill_code;
            1, 2:    s.cmd_byte = cfg.restart_code;
            default: s.cmd_byte = 8'($urandom);
        endcase
        s.emergency_code = ($urandom_range(11, 0) == 0) ? EMERGENCY_REQ : 8'($urandom);

        case ($urandom_range(7, 0))
            0: v = $urandom_range(4095, 0);
            1, 2: begin
                case ($urandom_range(4, 0))
                    0:       t = int'(cfg.normal_threshold);
                    1:       t = int'(cfg.low_floor);
                    2:       t = int'(cfg.low_exit_threshold);
                    3:       t = int'(cfg.extreme_exit_threshold);
                    default: t = int'(volt_thresh);
                endcase
                v = t + int'($urandom_range(2, 0)) - 1;
            end
            default: v = drift_volt + int'($urandom_range(300, 0)) - 150;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        drift_volt = v;
        s.battery_voltage = 12'(v);

        if ($urandom_range(1, 0) == 0) begin
            v = int'(cfg.rate_limit) + int'($urandom_range(2, 0)) - 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            s.angular_rate = 8'(v);
        end else begin
            s.angular_rate = 8'($urandom);
        end
        s.deploy_status = ($urandom_range(1, 0) == 0) ? DEPLOYED : 8'($urandom);
        s.image_status = ($urandom_range(1, 0) == 0) ? IMAGE_UPLINK : 8'($urandom);
        s.sat_position = 8'($urandom);
        s.region_bound = ($urandom_range(7, 0) == 0) ? s.sat_position : 8'($urandom);

        if (no_kill && !s.remove_before_flight && (cfg.launch_status & LAUNCH_MASK) == 8'd0
            && s.cmd_byte == cfg.kill_code)
            s.cmd_byte = s.cmd_byte + 8'd1;
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < 50)
            $display("ERROR result %0d: %s got %0d, expected %0d",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    // One register write; the shadow copy takes it at the same edge
    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            CFG_KILL_CODE:     cfg.kill_code = val[7:0];
            CFG_RESTART_CODE:  cfg.restart_code = val[7:0];
            CFG_LAUNCH_STATUS: cfg.launch_status = val[7:0];
            CFG_RATE_LIMIT:    cfg.rate_limit = val[7:0];
            CFG_NORMAL_THRESH: cfg.normal_threshold = val;
            CFG_LOW_FLOOR:     cfg.low_floor = val;
            CFG_LOW_EXIT:      cfg.low_exit_threshold = val;
            default:           cfg.extreme_exit_threshold = val;
        endcase
    endtask

    task automatic load_settings(input logic [11:0] kill, input logic [11:0] restart,
                                 input logic [11:0] launch, input logic [11:0] rate,
                                 input logic [11:0] normal, input logic [11:0] lo_floor,
                                 input logic [11:0] lo_exit, input logic [11:0] ex_exit);
        write_reg(CFG_KILL_CODE, kill);
        write_reg(CFG_RESTART_CODE, restart);
        write_reg(CFG_LAUNCH_STATUS, launch);
        write_reg(CFG_RATE_LIMIT, rate);
        write_reg(CFG_NORMAL_THRESH, normal);
        write_reg(CFG_LOW_FLOOR, lo_floor);
        write_reg(CFG_LOW_EXIT, lo_exit);
        write_reg(CFG_EXTREME_EXIT, ex_exit);
        settings_loaded++;
    endtask

    // Ordered random thresholds: floor <= normal <= low exit <= extreme exit
    task automatic load_random_settings(input logic [11:0] launch);
        int fl;
        int nt;
        int le;
        int ee;
        fl = $urandom_range(3000, 500);
        nt = fl + $urandom_range(800, 0);
        le = nt + $urandom_range(500, 0);
        ee = le + $urandom_range(500, 0);
        if (ee > 4095) ee = 4095;
        if (le > 4095) le = 4095;
        load_settings(12'($urandom), 12'($urandom), launch, 12'($urandom),
                      12'(nt), 12'(fl), 12'(le), 12'(ee));
    endtask

    // Sampled at the falling edge so every handshake of the edge has settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_random(input int n, input bit no_kill);
        repeat (n) pending_items.push_back(random_sample(no_kill));
    endtask

    // Sender: offers queued items, with random idle bursts
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(sequence_mode(in_item));
                samples_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!quiet && idle_odds != 0
                             && $urandom_range(idle_odds - 1, 0) == 0) begin
                    gap_left = $urandom_range(7, 0);
                    i_valid <= 1'b0;
                end else begin
                    in_item <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // Long hold-off, counted on its own, so the input side backs up
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Receiver: checks each result and applies backpressure
    int  stall_left = 0;
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with nothing pending, mode", int'(o_mode), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_mode !== want.mode)
                        flag_mismatch("mode", int'(o_mode), int'(want.mode));
                    if (o_mode_changed !== want.mode_changed)
                        flag_mismatch("mode_changed", int'(o_mode_changed),
                                      int'(want.mode_changed));
                    if (o_report_byte !== want.report_byte)
                        flag_mismatch("report_byte", int'(o_report_byte),
                                      int'(want.report_byte));
                    if (o_main_rails_action !== want.main_rails_action)
                        flag_mismatch("main_rails_action", int'(o_main_rails_action),
                                      int'(want.main_rails_action));
                    if (o_aux_rails_action !== want.aux_rails_action)
                        flag_mismatch("aux_rails_action", int'(o_aux_rails_action),
                                      int'(want.aux_rails_action));
                    if (o_halted !== want.halted)
                        flag_mismatch("halted", int'(o_halted), int'(want.halted));
                end
                results_checked++;
            end

            if (hold_left > 0) begin
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
                stall_left = $urandom_range(7, 0);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("power_mode_sequencer_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] stop_code;

        // shadow state matches the reset values
        cfg.kill_code = RST_KILL_CODE;
        cfg.restart_code = RST_RESTART_CODE;
        cfg.launch_status = RST_LAUNCH_STATUS;
        cfg.rate_limit = RST_RATE_LIMIT;
        cfg.normal_threshold = RST_NORMAL_THRESH;
        cfg.low_floor = RST_LOW_FLOOR;
        cfg.low_exit_threshold = RST_LOW_EXIT;
        cfg.extreme_exit_threshold = RST_EXTREME_EXIT;
        cur_mode = MODE_PREFLIGHT;
        volt_thresh = THRESHOLD_RESET;
        killed = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk under reset settings: every branch but launch and kill, strict compares,
        // hysteresis in and out of low and extreme low power
        pending_items.push_back(sample_of(1'b1, 8'h00, 8'h00, 12'd0,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd4095,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd4095,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'hFF, 8'hFF, 12'd3301,
                                          8'd129, 8'hA0, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3301,
                                          8'd255, 8'h9F, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3301,
                                          8'd128, 8'h00, 8'hFF, 8'd201, 8'd200));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3301,
                                          8'd0, 8'h00, 8'hFE, 8'd255, 8'd254));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3300,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3500,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3501,
                                          8'd0, 8'h00, 8'h00, 8'd7, 8'd7));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3000,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd3999,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd4000,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h02, 8'h00, 12'd4001,
                                          8'd0, 8'h00, 8'h00, 8'd255, 8'd254));
        pending_items.push_back(sample_of(1'b0, 8'h01, 8'h00, 12'd2000,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h01, 8'h00, 12'd2000,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'hFF, 8'h11, 12'd4095,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'hFF, 8'h00, 12'd0,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b1, 8'h01, 8'h11, 12'd4095,
                                          8'd0, 8'h00, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h80, 8'h10, 12'd4095,
                                          8'd255, 8'hA0, 8'h00, 8'd0, 8'd0));
        pending_items.push_back(sample_of(1'b0, 8'h7F, 8'hEE, 12'hAAA,
                                          8'd0, 8'h00, 8'hFF, 8'h55, 8'h54));
        wait_drained();

        // Random phases, each under its own settings
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_settings(12'($urandom), 12'($urandom), 12'hF00 | 12'($urandom_range(63, 0)),
                                 12'($urandom), 12'd3300, 12'd3000, 12'd3500, 12'd4000);
                1: load_settings(12'h000, 12'h0FF, 12'h03F, 12'h000,
                                 12'd0, 12'd0, 12'd0, 12'd0);
                2: load_settings(12'hFFF, 12'hF00, 12'hF3F, 12'hFFF,
                                 12'd4095, 12'd4095, 12'd4095, 12'd4095);
                3: load_random_settings(12'h040);
                4: load_random_settings(12'h080);
                default: load_random_settings(12'($urandom_range(63, 0)));
            endcase
            idle_odds = (phase == 4) ? 0 : ((phase == 5) ? 2 : 4);
            queue_random(PHASE_ITEMS, 1'b1);
            if (phase == 2)
                hold_req = 1'b1;
            wait_drained();
        end

        // Closing part, no idling: enter kill, then confirm it sticks
        quiet = 1'b1;
        stop_code = 8'($urandom);
        load_settings(12'(stop_code), 12'(stop_code ^ 8'h5A), 12'h000, 12'($urandom),
                      12'd3300, 12'd3000, 12'd3500, 12'd4000);
        queue_random(5, 1'b1);
        pending_items.push_back(sample_of(1'b0, stop_code, EMERGENCY_REQ, 12'($urandom),
                                          8'($urandom), 8'h00, 8'h00, 8'd0, 8'd0));
        queue_random(10, 1'b0);
        wait_drained();
        write_reg(CFG_LAUNCH_STATUS, 12'h0C0);
        write_reg(CFG_RATE_LIMIT, 12'($urandom));
        queue_random(10, 1'b0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_mismatch("results never returned", expected_results.size(), 0);

        $display("Sent %0d status samples under %0d register settings; checked %0d results.",
                 samples_sent, settings_loaded + 1, results_checked);
        $display("Saw %0d mode changes, %0d with rail actions, ending latched in kill.",
                 mode_changes, rail_events);
        if (mismatches == 0)
            $display("power_mode_sequencer_core_tb: PASS");
        else
            $display("power_mode_sequencer_core_tb: FAIL");
        $finish;
    end

endmodule
